FILE: sv/fltw_pkg.sv
// Shared types, constants and address helpers for the four-level page walker.
// No dependencies; imported by four_level_page_table_walker.
`timescale 1ns / 1ps

package fltw_pkg;

  // Walk geometry
  localparam int LEVELS     = 4;
  localparam int INDEX_BITS = 9;
  localparam int PAGE_SHIFT = 12;
  localparam int ENTRY_SHIFT = 3;

  // Field widths
  localparam int ADDR_W  = 52;
  localparam int VADDR_W = 48;
  localparam int ENTRY_W = 64;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // Page table entry flag bits
  localparam int PTE_PRESENT_BIT = 0;
  localparam int PTE_LARGE_BIT   = 7;

  typedef logic [LVL_W-1:0]      level_t;
  typedef logic [ADDR_W-1:0]     paddr_t;
  typedef logic [VADDR_W-1:0]    vaddr_t;
  typedef logic [INDEX_BITS-1:0] index_t;

  localparam level_t TOP_LEVEL = LVL_W'(LEVELS - 1);

  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_UNMAPPED = 2'd2
  } kind_t;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_ENTRY     = 1'b1
  } op_t;

  // Table index of a virtual address at a walk level
  function automatic index_t table_index(input vaddr_t va, input level_t lvl);
    index_t idx;
    idx = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (32'(lvl) == l) begin
        idx = INDEX_BITS'(va >> (PAGE_SHIFT + INDEX_BITS * l));
      end
    end
    return idx;
  endfunction

  // Entry address: table frame joined with the scaled index
  function automatic paddr_t entry_addr(input paddr_t tbl, input vaddr_t va,
                                        input level_t lvl);
    paddr_t frame;
    frame = {tbl[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    return frame | (ADDR_W'(table_index(va, lvl)) << ENTRY_SHIFT);
  endfunction

  // Page offset mask for a page that ends the walk at a given level
  function automatic paddr_t offset_mask(input level_t lvl);
    paddr_t mask;
    mask = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (32'(lvl) == l) begin
        mask = (ADDR_W'(1) << (PAGE_SHIFT + INDEX_BITS * l)) - ADDR_W'(1);
      end
    end
    return mask;
  endfunction

  // Large-page bit counts only at levels one and two, below the top
  function automatic logic large_level(input level_t lvl);
    return ((32'(lvl) == 1) || (32'(lvl) == 2)) && (32'(lvl) != LEVELS - 1);
  endfunction

endpackage

FILE: sv/four_level_page_table_walker.sv
// Path: a beat enters the input register; its result, if any, moves to the result register.
// Throughput: one beat per cycle unless the output stalls; an entry beat is decided
// combinationally, so walk time is set by the memory read latency outside the block.
// Reset: synchronous active-high rst empties both registers, idles the walk, zeroes the root.
// Depends on fltw_pkg.
`timescale 1ns / 1ps

module four_level_page_table_walker (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write_en,
  input  logic [fltw_pkg::ADDR_W-1:0]  cfg_write_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [fltw_pkg::VADDR_W-1:0] vaddr,
  input  logic [fltw_pkg::ENTRY_W-1:0] entry_data,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   kind,
  output logic [fltw_pkg::ADDR_W-1:0]  address,
  output logic [1:0]                   page_level
);

  import fltw_pkg::*;

  // Configuration and walk state
  paddr_t root_table_addr;
  vaddr_t walk_vaddr;
  level_t walk_level;
  logic   walk_busy;

  // Input register
  logic                 s1_valid;
  op_t                  s1_op;
  vaddr_t               s1_vaddr;
  logic [ENTRY_W-1:0]   s1_entry;

  // Result register
  kind_t  out_kind;
  paddr_t out_address;
  level_t out_level;

  // Decision
  logic   res_valid;
  kind_t  res_kind;
  paddr_t res_address;
  level_t res_level;
  vaddr_t walk_vaddr_next;
  level_t walk_level_next;
  logic   walk_busy_next;

  logic   out_ready;
  logic   s1_go;
  logic   in_take;
  paddr_t frame;

  assign out_ready = !out_valid || !out_stall;
  // Stage one drains when it has no result or the result register can take it
  assign s1_go     = s1_valid && (!res_valid || out_ready);
  assign in_stall  = s1_valid && !s1_go;
  assign in_take   = in_valid && !in_stall;

  assign frame = {s1_entry[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

  // Decide the held beat against the walk state
  always_comb begin
    res_valid       = 1'b0;
    res_kind        = KIND_READ;
    res_address     = '0;
    res_level       = '0;
    walk_vaddr_next = walk_vaddr;
    walk_level_next = walk_level;
    walk_busy_next  = walk_busy;
    if (s1_op == OP_TRANSLATE) begin
      if (!walk_busy) begin
        res_valid       = 1'b1;
        res_kind        = KIND_READ;
        res_address     = entry_addr(root_table_addr, s1_vaddr, TOP_LEVEL);
        res_level       = TOP_LEVEL;
        walk_vaddr_next = s1_vaddr;
        walk_level_next = TOP_LEVEL;
        walk_busy_next  = 1'b1;
      end
    end else if (walk_busy) begin
      res_valid = 1'b1;
      if (!s1_entry[PTE_PRESENT_BIT]) begin
        res_kind       = KIND_UNMAPPED;
        res_address    = '0;
        res_level      = walk_level;
        walk_busy_next = 1'b0;
      end else if (s1_entry[PTE_LARGE_BIT] && large_level(walk_level)) begin
        res_kind       = KIND_DONE;
        res_address    = (frame & ~offset_mask(walk_level)) |
                         (ADDR_W'(walk_vaddr) & offset_mask(walk_level));
        res_level      = walk_level;
        walk_busy_next = 1'b0;
      end else if (walk_level == '0) begin
        res_kind       = KIND_DONE;
        res_address    = frame | ADDR_W'(walk_vaddr[PAGE_SHIFT-1:0]);
        res_level      = '0;
        walk_busy_next = 1'b0;
      end else begin
        res_kind        = KIND_READ;
        walk_level_next = walk_level - LVL_W'(1);
        res_address     = entry_addr(frame, walk_vaddr, walk_level_next);
        res_level       = walk_level_next;
      end
    end
  end

  // Root register
  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_addr <= '0;
    end else if (cfg_write_en) begin
      root_table_addr <= cfg_write_data;
    end
  end

  // Walk state advances as stage one drains
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_vaddr <= '0;
      walk_level <= '0;
      walk_busy  <= 1'b0;
    end else if (s1_go) begin
      walk_vaddr <= walk_vaddr_next;
      walk_level <= walk_level_next;
      walk_busy  <= walk_busy_next;
    end
  end

  // Input register: load a beat, drop when drained
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op    <= op_t'(op);
      s1_vaddr <= vaddr;
      s1_entry <= entry_data;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_kind    <= res_kind;
      out_address <= res_address;
      out_level   <= res_level;
    end
  end

  assign kind       = 2'(out_kind);
  assign address    = out_address;
  assign page_level = 2'(out_level);

  // A finished walk leaves the walker idle
  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    (s1_go && res_valid && res_kind != KIND_READ) |=> !walk_busy)
    else $error("walk still busy after a final result");

  // A read request always leaves a walk in progress
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (s1_go && res_valid && res_kind == KIND_READ) |=> walk_busy)
    else $error("read request issued without an active walk");

  // Walk level stays within the table hierarchy
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    walk_busy |-> (32'(walk_level) <= LEVELS - 1))
    else $error("walk level out of range");

  // Stall only when the input register holds a beat that cannot move
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && res_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

endmodule
